[rtl/scdp_pkg.sv]
package scdp_pkg;

  localparam int MAX_WORDS_DEF = 4095;

  localparam int COST_W = 10;
  localparam int LINE_W = 16;
  localparam int PFX_W  = 23;
  localparam int BEST_W = 48;
  localparam int LIFT_W = BEST_W + 1;
  localparam int DIFF_W = LIFT_W + 1;
  localparam int GAP_W  = PFX_W + 1;
  localparam int SQ_W   = 2 * PFX_W;
  localparam int FPR_W  = PFX_W + GAP_W;
  localparam int LO_W   = GAP_W;
  localparam int HI_W   = DIFF_W - LO_W;
  localparam int PH_W   = HI_W + GAP_W + 1;
  localparam int PL_W   = LO_W + GAP_W;
  localparam int PROD_W = PH_W + LO_W;

  localparam logic [PFX_W-1:0]  PFX_MAX  = '1;
  localparam logic [BEST_W-1:0] BEST_MAX = '1;

  typedef struct packed {
    logic [PFX_W-1:0] prefix;
    logic             last;
  } scdp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scdp_qstat_t;

  typedef struct packed {
    logic [PFX_W-1:0]  prefix;
    logic [BEST_W-1:0] best;
    logic [LIFT_W-1:0] lift;
  } scdp_entry_t;

endpackage

[rtl/scdp_fifo.sv]
module scdp_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  scdp_pkg::scdp_item_t push_item,
  input  logic               pop,
  output scdp_pkg::scdp_item_t pop_item,
  output scdp_pkg::scdp_qstat_t stat
);
  import scdp_pkg::*;

  scdp_item_t  slots [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/scdp_front.sv]
module scdp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        word_valid,
  output logic                        word_stall,
  input  logic [scdp_pkg::COST_W-1:0] word_cost,
  input  logic                        last_word,
  input  scdp_pkg::scdp_qstat_t       qstat,
  output logic                        push,
  output scdp_pkg::scdp_item_t        push_item
);
  import scdp_pkg::*;

  logic [PFX_W-1:0] prefix;
  logic [PFX_W:0]   sum;
  logic [PFX_W-1:0] sum_sat;

  assign word_stall = qstat.full;
  assign push       = word_valid && !word_stall;
  assign sum        = {1'b0, prefix} + {{(PFX_W + 1 - COST_W){1'b0}}, word_cost};
  assign sum_sat    = sum[PFX_W] ? PFX_MAX : sum[PFX_W-1:0];

  assign push_item.prefix = sum_sat;
  assign push_item.last   = last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= '0;
    end else if (push) begin
      prefix <= last_word ? '0 : sum_sat;
    end
  end

endmodule

[rtl/scdp_back.sv]
module scdp_back #(
  parameter int MAX_WORDS = scdp_pkg::MAX_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [scdp_pkg::LINE_W-1:0]  line_cost,
  input  scdp_pkg::scdp_item_t         item,
  input  scdp_pkg::scdp_qstat_t        qstat,
  output logic                         pop,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [scdp_pkg::BEST_W-1:0]  best_cost,
  output logic                         case_done
);
  import scdp_pkg::*;

  localparam int DEPTH = MAX_WORDS + 1;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_FTEST, S_FCMP, S_FWAIT, S_BMUL, S_BSUM, S_BLIFT,
    S_TTEST, S_TMUL, S_TSUM, S_TCMP, S_TWAIT, S_PUSH
  } state_t;

  state_t state;

  scdp_entry_t mem [DEPTH];
  scdp_entry_t rd0;
  scdp_entry_t rd1;
  scdp_entry_t e0;
  scdp_entry_t e1;
  logic        z0;
  logic        z1;
  logic [AW-1:0] a0;
  logic [AW-1:0] a1;
  logic          we;
  logic [AW:0]   tail_inc;
  logic          room;
  logic          hold;

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic          tail_mode;

  logic [PFX_W-1:0]  s;
  logic              last;
  logic [BEST_W-1:0] best;
  logic [LIFT_W-1:0] ynew;
  logic [SQ_W-1:0]   sq;
  logic [SQ_W-1:0]   ss;
  logic [LIFT_W-1:0] base;
  logic [LIFT_W-1:0] best_raw;

  logic signed [DIFF_W-1:0] num;
  logic [FPR_W-1:0]         fprod;
  logic [DIFF_W-1:0]        n1;
  logic [DIFF_W-1:0]        n2;
  logic [GAP_W-1:0]         g1;
  logic [GAP_W-1:0]         g2;
  logic signed [PH_W-1:0]   ph1;
  logic signed [PH_W-1:0]   ph2;
  logic [PL_W-1:0]          pl1;
  logic [PL_W-1:0]          pl2;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;

  // entry 0 is never written; a read of address 0 yields the empty split point (all zero)
  assign e0 = z0 ? '0 : rd0;
  assign e1 = z1 ? '0 : rd1;

  assign a0 = tail_mode ? tail : head;
  assign a1 = tail_mode ? tail - AW'(1) : head + AW'(1);

  assign tail_inc = {1'b0, tail} + (AW + 1)'(1);
  assign room     = tail_inc < (AW + 1)'(DEPTH);
  assign hold     = result_valid && result_stall;
  assign we       = (state == S_PUSH) && !hold && room;
  assign pop      = (state == S_IDLE) && !qstat.empty;
  assign best_raw = base + {{(LIFT_W - SQ_W){1'b0}}, sq};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[tail_inc[AW-1:0]] <= '{prefix: s, best: best, lift: ynew};
    end
    rd0 <= mem[a0];
    rd1 <= mem[a1];
    z0  <= (a0 == '0);
    z1  <= (a1 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      tail_mode    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_PUSH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            s     <= item.prefix;
            last  <= item.last;
            state <= S_FTEST;
          end
        end
        S_FTEST: begin
          num   <= $signed({1'b0, e1.lift} - {1'b0, e0.lift});
          fprod <= s * {e1.prefix - e0.prefix, 1'b0};
          state <= (head < tail) ? S_FCMP : S_BMUL;
        end
        S_FCMP: begin
          if (num <= $signed({{(DIFF_W - FPR_W){1'b0}}, fprod})) begin
            head  <= head + AW'(1);
            state <= S_FWAIT;
          end else begin
            state <= S_BMUL;
          end
        end
        S_FWAIT: state <= S_FTEST;
        S_BMUL: begin
          sq        <= (s - e0.prefix) * (s - e0.prefix);
          ss        <= s * s;
          base      <= {1'b0, e0.best} + {{(LIFT_W - LINE_W){1'b0}}, line_cost};
          tail_mode <= 1'b1;
          state     <= S_BSUM;
        end
        S_BSUM: begin
          best  <= best_raw[BEST_W] ? BEST_MAX : best_raw[BEST_W-1:0];
          state <= S_BLIFT;
        end
        S_BLIFT: begin
          ynew  <= {1'b0, best} + {{(LIFT_W - SQ_W){1'b0}}, ss};
          state <= S_TTEST;
        end
        S_TTEST: begin
          n1    <= {1'b0, ynew} - {1'b0, e0.lift};
          n2    <= {1'b0, e0.lift} - {1'b0, e1.lift};
          g1    <= {e0.prefix - e1.prefix, 1'b0};
          g2    <= {s - e0.prefix, 1'b0};
          state <= (head < tail) ? S_TMUL : S_PUSH;
        end
        S_TMUL: begin
          // signed high part and unsigned low part of each slope product
          ph1   <= $signed(n1[DIFF_W-1:LO_W]) * $signed({1'b0, g1});
          ph2   <= $signed(n2[DIFF_W-1:LO_W]) * $signed({1'b0, g2});
          pl1   <= n1[LO_W-1:0] * g1;
          pl2   <= n2[LO_W-1:0] * g2;
          state <= S_TSUM;
        end
        S_TSUM: begin
          p1    <= $signed({ph1, {LO_W{1'b0}}}) + $signed({{(PROD_W - PL_W){1'b0}}, pl1});
          p2    <= $signed({ph2, {LO_W{1'b0}}}) + $signed({{(PROD_W - PL_W){1'b0}}, pl2});
          state <= S_TCMP;
        end
        S_TCMP: begin
          if (p1 <= p2) begin
            tail  <= tail - AW'(1);
            state <= S_TWAIT;
          end else begin
            state <= S_PUSH;
          end
        end
        S_TWAIT: state <= S_TTEST;
        S_PUSH: begin
          if (!hold) begin
            result_valid <= 1'b1;
            best_cost    <= best;
            case_done    <= last;
            tail_mode    <= 1'b0;
            state        <= S_IDLE;
            if (last) begin
              head <= '0;
              tail <= '0;
            end else if (room) begin
              tail <= tail_inc[AW-1:0];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/segment_cost_dp_convex_hull.sv]
// Segment-cost dynamic programme over a stream of word costs, one word in and one best_cost
// out per item, using a monotone convex-hull deque of split points held in an on-chip
// memory of MAX_WORDS+1 entries. A front stage keeps the saturating prefix sum and queues
// words in a two-word buffer; the back sequencer evaluates them one at a time. For each word
// the back drops front points that no longer give the best split, computes best_cost and the
// new point's lift, and pops tail points before it pushes the new point; a stalled result
// holds the back. The back uses registered memory reads and splits the wide slope products.
// line_cost may be written only while the block is idle; last_word ends a case.
module segment_cost_dp_convex_hull #(
  parameter int MAX_WORDS = scdp_pkg::MAX_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [scdp_pkg::LINE_W-1:0]  cfg_data,
  input  logic                         word_valid,
  output logic                         word_stall,
  input  logic [scdp_pkg::COST_W-1:0]  word_cost,
  input  logic                         last_word,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [scdp_pkg::BEST_W-1:0]  best_cost,
  output logic                         case_done
);
  import scdp_pkg::*;

  logic [LINE_W-1:0] line_cost;
  logic              push;
  logic              pop;
  scdp_item_t        push_item;
  scdp_item_t        pop_item;
  scdp_qstat_t       qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cost <= '0;
    end else if (cfg_write) begin
      line_cost <= cfg_data;
    end
  end

  scdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word_cost  (word_cost),
    .last_word  (last_word),
    .qstat      (qstat),
    .push       (push),
    .push_item  (push_item)
  );

  scdp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (qstat)
  );

  scdp_back #(
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .line_cost    (line_cost),
    .item         (pop_item),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .best_cost    (best_cost),
    .case_done    (case_done)
  );

endmodule

[rtl/scdp_checker.sv]
module scdp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         word_stall,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [scdp_pkg::BEST_W-1:0]  best_cost,
  input logic                         case_done
);

  // the input buffer is empty after reset
  a_reset_open: assert property (@(posedge clk) rst |=> !word_stall)
    else $error("word_stall high after reset");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_hold_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(best_cost))
    else $error("stalled best_cost changed");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(case_done))
    else $error("stalled case_done changed");

endmodule

bind segment_cost_dp_convex_hull scdp_checker u_scdp_checker (
  .clk          (clk),
  .rst          (rst),
  .word_stall   (word_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .best_cost    (best_cost),
  .case_done    (case_done)
);
